@@ hw/rtl/nfa_state_set_matcher_defines.svh @@
// Assertion macros for the NFA state-set matcher.
`ifndef NFA_STATE_SET_MATCHER_DEFINES_SVH
`define NFA_STATE_SET_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define NSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/nsm_pkg.sv @@
// Shared types, constants and helper functions for the NFA state-set matcher.
`timescale 1ns / 1ps
package nsm_pkg;

  localparam int NUM_STATES    = 16;
  localparam int STATE_BITS    = 4;
  localparam int SYMBOL_BITS   = 8;
  localparam int SYM_PORT_BITS = 8;
  localparam int SET_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int MAX_TRANS_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_CONSUME = 2'd2,
    ACT_END     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STATUS_VERDICT  = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_START = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_STATE = 2'd0,
    REG_ACCEPT_MASK = 2'd1
  } reg_idx_t;

  typedef struct packed {
    action_t                 op;
    logic [STATE_BITS-1:0]   src;
    logic [SYMBOL_BITS-1:0]  sym;
    logic [STATE_BITS-1:0]   dst;
  } cmd_t;

  typedef struct packed {
    logic [STATE_BITS-1:0]   src;
    logic [SYMBOL_BITS-1:0]  label;
    logic [STATE_BITS-1:0]   dst;
  } entry_t;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic table_full;
  } back_status_t;

  function automatic logic state_ok(logic [STATE_BITS-1:0] s);
    state_ok = ({1'b0, s} < (STATE_BITS + 1)'(NUM_STATES));
  endfunction

  function automatic logic [SET_BITS-1:0] state_bit(logic [STATE_BITS-1:0] s);
    logic [SET_BITS-1:0] b;
    b = '0;
    if (state_ok(s)) begin
      b[s] = 1'b1;
    end
    state_bit = b;
  endfunction

endpackage

@@ hw/rtl/nsm_front.sv @@
// Front end: accept input transactions, drop ignored adds, register the command.
`timescale 1ns / 1ps
module nsm_front import nsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [STATE_BITS-1:0]    in_from_state,
  input  logic [SYM_PORT_BITS-1:0] in_symbol,
  input  logic [STATE_BITS-1:0]    in_to_state,
  output cmd_t                     cmd_o,
  output logic                     cmd_valid,
  input  logic                     cmd_ready
);

  cmd_t    cmd_r, cmd_nxt;
  logic    valid_r, valid_nxt;
  logic    take, keep;
  action_t act;

  assign in_stall  = valid_r && !cmd_ready;
  assign cmd_o     = cmd_r;
  assign cmd_valid = valid_r;

  always_comb begin
    act  = action_t'(in_action);
    take = in_valid && !in_stall;
    keep = 1'b1;
    if (act == ACT_ADD) begin
      keep = state_ok(in_from_state) && state_ok(in_to_state);
    end
    cmd_nxt.op  = act;
    cmd_nxt.src = in_from_state;
    cmd_nxt.sym = in_symbol[SYMBOL_BITS-1:0];
    cmd_nxt.dst = in_to_state;
    valid_nxt   = valid_r;
    if (take && keep) begin
      valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

@@ hw/rtl/nsm_queue.sv @@
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
module nsm_queue import nsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      push_cmd,
  input  logic      push,
  output logic      push_ready,
  output cmd_t      pop_cmd,
  output logic      pop_valid,
  input  logic      pop,
  output q_status_t st_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != (PW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rp_r];
  assign st_o.empty = !pop_valid;
  assign st_o.full  = !push_ready;

  always_comb begin
    do_push = push && push_ready;
    do_pop  = pop && pop_valid;
    wp_nxt  = do_push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/nsm_back.sv @@
// Back end: transition table, state sets, table scan, config registers, result register.
`timescale 1ns / 1ps
module nsm_back import nsm_pkg::*; #(
  parameter int MAX_TRANSITIONS = MAX_TRANS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                q_cmd,
  input  logic                q_valid,
  output logic                q_pop,
  input  cfg_wr_t             cfg,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic                out_accepted,
  output logic [SET_BITS-1:0] out_state_set,
  output back_status_t        st_o
);

  localparam int CW = $clog2(MAX_TRANSITIONS + 1);
  localparam int AW = $clog2(MAX_TRANSITIONS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } fsm_t;

  entry_t                 mem [MAX_TRANSITIONS];
  entry_t                 rd_data_r;
  entry_t                 wr_data;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;

  fsm_t                   state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   pend_r, pend_nxt;
  logic [SET_BITS-1:0]    has_r, has_nxt;
  logic [SET_BITS-1:0]    active_r, active_nxt;
  logic [SET_BITS-1:0]    stopped_r, stopped_nxt;
  logic [SET_BITS-1:0]    moved_r, moved_nxt;
  logic [SET_BITS-1:0]    next_r, next_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [STATE_BITS-1:0]  start_r, start_nxt;
  logic [SET_BITS-1:0]    mask_r, mask_nxt;
  logic                   ov_r, ov_nxt;
  status_t                os_r, os_nxt;
  logic                   oa_r, oa_nxt;
  logic [SET_BITS-1:0]    oset_r, oset_nxt;

  logic                   full, out_free, needs_out, load_out, issue;
  logic [SET_BITS-1:0]    final_set, acc_set;

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_accepted    = oa_r;
  assign out_state_set   = oset_r;
  assign st_o.busy       = (state_r == ST_SCAN);
  assign st_o.table_full = full;

  always_comb begin
    full      = (count_r == CW'(MAX_TRANSITIONS));
    out_free  = !ov_r || !out_stall;
    needs_out = (q_cmd.op == ACT_END) || ((q_cmd.op == ACT_ADD) && full);
    final_set = active_r | stopped_r;
    acc_set   = final_set & mask_r;
    issue     = 1'b0;

    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    has_nxt     = has_r;
    active_nxt  = active_r;
    stopped_nxt = stopped_r;
    moved_nxt   = moved_r;
    next_nxt    = next_r;
    sym_nxt     = sym_r;
    start_nxt   = start_r;
    mask_nxt    = mask_r;
    os_nxt      = os_r;
    oa_nxt      = oa_r;
    oset_nxt    = oset_r;
    load_out    = 1'b0;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    rd_addr     = idx_r[AW-1:0];
    wr_data.src   = q_cmd.src;
    wr_data.label = q_cmd.sym;
    wr_data.dst   = q_cmd.dst;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && (!needs_out || out_free)) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            ACT_CLEAR: begin
              count_nxt   = '0;
              has_nxt     = '0;
              active_nxt  = state_bit(start_r);
              stopped_nxt = '0;
            end
            ACT_ADD: begin
              if (full) begin
                load_out = 1'b1;
                os_nxt   = STATUS_FULL;
                oa_nxt   = 1'b0;
                oset_nxt = '0;
              end else begin
                wr_en     = 1'b1;
                has_nxt   = has_r | state_bit(q_cmd.src);
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_CONSUME: begin
              state_nxt = ST_SCAN;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              moved_nxt = '0;
              next_nxt  = '0;
              sym_nxt   = q_cmd.sym;
            end
            ACT_END: begin
              load_out = 1'b1;
              if ((has_r & state_bit(start_r)) == '0) begin
                os_nxt   = STATUS_NO_START;
                oa_nxt   = 1'b0;
                oset_nxt = '0;
              end else if (acc_set != '0) begin
                os_nxt   = STATUS_VERDICT;
                oa_nxt   = 1'b1;
                oset_nxt = acc_set;
              end else begin
                os_nxt   = STATUS_VERDICT;
                oa_nxt   = 1'b0;
                oset_nxt = final_set;
              end
              active_nxt  = state_bit(start_r);
              stopped_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        issue    = (idx_r < count_r);
        rd_en    = issue;
        pend_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pend_r && ((active_r & state_bit(rd_data_r.src)) != '0)
            && (rd_data_r.label == sym_r)) begin
          moved_nxt = moved_r | state_bit(rd_data_r.src);
          next_nxt  = next_r | state_bit(rd_data_r.dst);
        end
        if (!issue && !pend_r) begin
          stopped_nxt = stopped_r | (active_r & ~moved_r);
          active_nxt  = next_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg.we) begin
      case (reg_idx_t'(cfg.idx))
        REG_START_STATE: begin
          start_nxt   = cfg.data[STATE_BITS-1:0];
          active_nxt  = state_bit(cfg.data[STATE_BITS-1:0]);
          stopped_nxt = '0;
        end
        REG_ACCEPT_MASK: begin
          mask_nxt = cfg.data[SET_BITS-1:0];
        end
        default: ;
      endcase
    end

    ov_nxt = ov_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      pend_r    <= 1'b0;
      has_r     <= '0;
      active_r  <= state_bit('0);
      stopped_r <= '0;
      start_r   <= '0;
      mask_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
      has_r     <= has_nxt;
      active_r  <= active_nxt;
      stopped_r <= stopped_nxt;
      start_r   <= start_nxt;
      mask_r    <= mask_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    moved_r <= moved_nxt;
    next_r  <= next_nxt;
    sym_r   <= sym_nxt;
    if (load_out) begin
      os_r   <= os_nxt;
      oa_r   <= oa_nxt;
      oset_r <= oset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/nfa_state_set_matcher.sv @@
// Top level of the NFA state-set matcher: front end, command queue, back end.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_action, in_from_state, in_symbol, in_to_state
//  out      output     out_valid/out_stall out_status, out_accepted, out_state_set
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Consume holds the back end while the scan reads one entry per cycle through the single
// registered read port of the table memory. Clear, add and end of string need no scan;
// the front-end register and the queue stand ahead of the back end.
// Synchronous active-low reset; the table needs no clearing pass.
// The front end stalls only when its register and the queue are full; the back end
// holds results for end of string and table full until the result register is free.
`timescale 1ns / 1ps
`include "nfa_state_set_matcher_defines.svh"
module nfa_state_set_matcher import nsm_pkg::*; #(
  parameter int MAX_TRANSITIONS = MAX_TRANS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [STATE_BITS-1:0]    in_from_state,
  input  logic [SYM_PORT_BITS-1:0] in_symbol,
  input  logic [STATE_BITS-1:0]    in_to_state,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic                     out_accepted,
  output logic [SET_BITS-1:0]      out_state_set,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cmd_t         fr_cmd, q_cmd;
  logic         fr_valid, q_ready, q_valid, q_pop;
  q_status_t    q_st;
  back_status_t back_st;
  cfg_wr_t      cfg;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid && cfg_ready;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;

  nsm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_from_state (in_from_state),
    .in_symbol     (in_symbol),
    .in_to_state   (in_to_state),
    .cmd_o         (fr_cmd),
    .cmd_valid     (fr_valid),
    .cmd_ready     (q_ready)
  );

  nsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (fr_cmd),
    .push       (fr_valid),
    .push_ready (q_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .st_o       (q_st)
  );

  nsm_back #(
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_cmd         (q_cmd),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_accepted  (out_accepted),
    .out_state_set (out_state_set),
    .st_o          (back_st)
  );

  `NSM_ASSERT(a_no_pop_while_scan, clk, rst_n, !(q_pop && back_st.busy), "pop during table scan")
  `NSM_ASSERT(a_queue_flags, clk, rst_n, !(q_st.full && q_st.empty), "queue full and empty")
  `NSM_ASSERT(a_stall_when_full, clk, rst_n, !(q_st.full && fr_valid) || in_stall, "no stall on full queue")
  `NSM_ASSERT_NEXT(a_result_from_pop, clk, rst_n, !out_valid && !q_pop, !out_valid, "result without command")

endmodule
